// File: hw/rtl/sbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants of the sorted sparse byte memory.
// ----------------------------------------------------------------------------
package sbm_pkg;

   localparam int unsigned ADDR_W = 64;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned SIZE_W = 4;
   localparam int unsigned OP_W   = 2;
   localparam int unsigned CC_W   = 4;

   typedef enum logic [1:0] {
      OP_READ_VALUE = 2'd0,
      OP_READ_CLASS = 2'd1,
      OP_WRITE      = 2'd2,
      OP_SET_CLASS  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NOT_FOUND    = 2'd1,
      ST_UNDETERMINED = 2'd2,
      ST_FULL         = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] address;
      logic [3:0]  size;
      logic [63:0] write_value;
      logic [3:0]  class_code;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic [63:0] overflow;
      logic        all_defined;
      logic        not_present;
      logic        undetermined;
      logic [1:0]  status;
   } rsp_type;

   // datapath commands issued by the controller
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,       // latch request, clear flags
      CMD_SRCH_INIT,  // lo=0 hi=count, key = addr + byte
      CMD_SRCH_RD,    // read address_store[mid]
      CMD_SRCH_CMP,   // compare registered read
      CMD_COUNT_MISS, // count a missing byte, next byte
      CMD_RDCHK_RD,   // read entry at base + byte
      CMD_RDCHK_EVAL, // evaluate entry for read
      CMD_SHIFT_RD,   // read entry at shift pointer - 1
      CMD_SHIFT_WR,   // write it at shift pointer, step down
      CMD_INS_WR,     // write new entry at pos
      CMD_UPD_RD,     // read byte entry at pos
      CMD_UPD_WR,     // write updated byte entry
      CMD_NEXT_BYTE,  // advance byte index
      CMD_FINISH,     // build result
      CMD_WR_START    // byte index and miss count back to zero
   } cmd_type;

   typedef struct packed {
      logic found;       // last search hit
      logic srch_done;   // lo >= hi or hit
      logic last_byte;   // byte index is size-1
      logic shift_done;  // shift pointer reached pos
      logic no_room;     // count + missing > entries
      logic is_read;
      logic is_rdval;
   } stat_type;

endpackage
`default_nettype wire

// File: hw/rtl/sbm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface sbm_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sbm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_ram
// Single port RAM with registered read.
// ----------------------------------------------------------------------------
module sbm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// File: hw/rtl/sbm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_datapath
// Request registers, search bounds, shift pointer, tables and result flags.
// ----------------------------------------------------------------------------
module sbm_datapath #(
   parameter int unsigned ENTRIES           = 1024,
   parameter int unsigned MAX_SEGMENT_BYTES = 8,
   parameter int unsigned CLASS_BITS        = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sbm_pkg::cmd_type cmd,
   input  wire sbm_pkg::req_type req,
   output sbm_pkg::stat_type     stat,
   output sbm_pkg::rsp_type      rsp
);
   localparam int unsigned IW = $clog2(ENTRIES);
   localparam int unsigned CW = IW + 1;
   localparam int unsigned BW = 8 + CLASS_BITS;

   logic [1:0]            op_ff;
   logic [63:0]           addr_ff, wv_ff;
   logic [3:0]            size_ff;
   logic [CLASS_BITS-1:0] cc_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         lo_ff, hi_ff, miss_ff, sp_ff;
   logic [CW-1:0]         base_ff;
   logic [2:0]            j_ff;
   logic [63:0]           key_ff;
   logic                  found_ff;
   logic [63:0]           data_ff;
   logic                  np_ff, und_ff;
   logic [63:0]           a_tmp_ff;
   logic [BW-1:0]         b_tmp_ff;

   logic [CW-1:0]  mid;
   logic [IW-1:0]  ram_addr;
   logic           a_we, b_we;
   logic [63:0]    a_wd, a_rd;
   logic [BW-1:0]  b_wd, b_rd;
   logic [CW-1:0]  idx;
   logic [3:0]     size_sat;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx = base_ff + CW'(j_ff);

   always_comb begin
      size_sat = req.size;
      if (size_sat == 4'd0) size_sat = 4'd1;
      if (size_sat > 4'(MAX_SEGMENT_BYTES)) size_sat = 4'(MAX_SEGMENT_BYTES);
   end

   always_comb begin
      ram_addr = '0;
      a_we = 1'b0;
      b_we = 1'b0;
      a_wd = a_tmp_ff;
      b_wd = b_tmp_ff;
      unique case (cmd)
         sbm_pkg::CMD_SRCH_RD:  ram_addr = mid[IW-1:0];
         sbm_pkg::CMD_RDCHK_RD: ram_addr = idx[IW-1:0];
         sbm_pkg::CMD_SHIFT_RD: ram_addr = IW'(sp_ff - 1'b1);
         sbm_pkg::CMD_SHIFT_WR: begin
            ram_addr = sp_ff[IW-1:0];
            a_we = 1'b1;
            b_we = 1'b1;
            a_wd = a_rd;
            b_wd = b_rd;
         end
         sbm_pkg::CMD_INS_WR: begin
            ram_addr = lo_ff[IW-1:0];
            a_we = 1'b1;
            b_we = 1'b1;
            a_wd = key_ff;
            b_wd = '0;
         end
         sbm_pkg::CMD_UPD_RD: ram_addr = lo_ff[IW-1:0];
         sbm_pkg::CMD_UPD_WR: begin
            ram_addr = lo_ff[IW-1:0];
            b_we = 1'b1;
            if (op_ff == sbm_pkg::OP_WRITE) begin
               b_wd = {CLASS_BITS'(1), wv_ff[8*j_ff +: 8]};
            end else begin
               b_wd = {cc_ff, b_rd[7:0]};
            end
         end
         default: ram_addr = '0;
      endcase
   end

   sbm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_addr_ram (
      .clock(clock), .wr_en(a_we), .addr(ram_addr), .wr_data(a_wd), .rd_data(a_rd));
   sbm_ram #(.WIDTH(BW), .DEPTH(ENTRIES)) u_byte_ram (
      .clock(clock), .wr_en(b_we), .addr(ram_addr), .wr_data(b_wd), .rd_data(b_rd));

   always_comb begin
      count_in = count_ff;
      if (cmd == sbm_pkg::CMD_INS_WR) count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd)
         sbm_pkg::CMD_LOAD: begin
            op_ff    <= req.operation;
            addr_ff  <= req.address;
            size_ff  <= size_sat;
            wv_ff    <= req.write_value;
            cc_ff    <= CLASS_BITS'(req.class_code);
            j_ff     <= '0;
            miss_ff  <= '0;
            np_ff    <= 1'b0;
            und_ff   <= 1'b0;
            data_ff  <= '0;
         end
         sbm_pkg::CMD_SRCH_INIT: begin
            lo_ff    <= '0;
            hi_ff    <= count_ff;
            key_ff   <= addr_ff + 64'(j_ff);
            found_ff <= 1'b0;
         end
         sbm_pkg::CMD_SRCH_CMP: begin
            if (a_rd == key_ff) begin
               found_ff <= 1'b1;
               lo_ff    <= mid;
            end else if (a_rd > key_ff) begin
               hi_ff <= mid;
            end else begin
               lo_ff <= mid + 1'b1;
            end
            base_ff <= mid;
         end
         sbm_pkg::CMD_COUNT_MISS: begin
            if (!found_ff) miss_ff <= miss_ff + 1'b1;
            j_ff <= j_ff + 1'b1;
         end
         sbm_pkg::CMD_WR_START: begin
            j_ff    <= '0;
            miss_ff <= '0;
         end
         sbm_pkg::CMD_RDCHK_RD: ;
         sbm_pkg::CMD_RDCHK_EVAL: begin
            if (idx < count_ff && a_rd == addr_ff + 64'(j_ff)) begin
               if (b_rd[BW-1:8] == '0) und_ff <= 1'b1;
               data_ff[8*j_ff +: 8] <= b_rd[7:0];
            end else begin
               np_ff <= 1'b1;
            end
            j_ff <= j_ff + 1'b1;
         end
         sbm_pkg::CMD_SHIFT_RD: begin
            if (!found_ff) begin
               // no-op on hit; the controller skips shifting
            end
         end
         sbm_pkg::CMD_SHIFT_WR: sp_ff <= sp_ff - 1'b1;
         sbm_pkg::CMD_NEXT_BYTE: j_ff <= j_ff + 1'b1;
         sbm_pkg::CMD_FINISH: begin
            if (!found_ff && (op_ff == sbm_pkg::OP_READ_VALUE ||
                              op_ff == sbm_pkg::OP_READ_CLASS)) begin
               np_ff <= 1'b1;
            end
         end
         default: ;
      endcase
      // search base for reads is the first byte's index
      if (cmd == sbm_pkg::CMD_LOAD) begin
         base_ff <= '0;
      end else if (cmd == sbm_pkg::CMD_SRCH_INIT) begin
         sp_ff <= count_ff;
      end
      a_tmp_ff <= a_rd;
      b_tmp_ff <= b_rd;
   end

   always_comb begin
      stat.found      = found_ff;
      stat.srch_done  = found_ff || (lo_ff >= hi_ff);
      stat.last_byte  = (4'(j_ff) + 4'd1 >= size_ff);
      stat.shift_done = (sp_ff <= lo_ff);
      stat.no_room    = (32'(count_ff) + 32'(miss_ff) > 32'(ENTRIES));
      stat.is_read    = (op_ff == sbm_pkg::OP_READ_VALUE) || (op_ff == sbm_pkg::OP_READ_CLASS);
      stat.is_rdval   = (op_ff == sbm_pkg::OP_READ_VALUE);
   end

   // result assembly, valid when the controller finishes
   logic [63:0] ovf_mask;
   always_comb begin
      ovf_mask = '0;
      for (int k = 0; k < 8; k++) begin
         if (4'(k) < size_ff) ovf_mask[8*k +: 8] = 8'hFF;
      end
      rsp = '0;
      if (stat.is_read) begin
         rsp.not_present  = np_ff;
         rsp.undetermined = und_ff;
         rsp.all_defined  = !np_ff && !und_ff;
         if (stat.is_rdval) begin
            if (np_ff) rsp.status = sbm_pkg::ST_NOT_FOUND;
            else if (und_ff) rsp.status = sbm_pkg::ST_UNDETERMINED;
            else rsp.read_data = data_ff;
         end
      end else if (stat.no_room) begin
         rsp.status = sbm_pkg::ST_FULL;
      end else if (op_ff == sbm_pkg::OP_WRITE) begin
         rsp.overflow = wv_ff & ~ovf_mask;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/sbm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_ctrl
// Sequencer: searches, room check, shift and insert, result handshake.
// ----------------------------------------------------------------------------
module sbm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire sbm_pkg::stat_type stat,
   output sbm_pkg::cmd_type       cmd
);
   typedef enum logic [4:0] {
      S_IDLE, S_RD_INIT, S_RD_SRD, S_RD_SCMP, S_RD_CRD, S_RD_CEV,
      S_CM_INIT, S_CM_SRD, S_CM_SCMP, S_CM_NEXT,
      S_W_CHK, S_W_INIT, S_W_SRD, S_W_SCMP, S_W_SHRD, S_W_SHWR, S_W_INS,
      S_W_URD, S_W_UWR, S_W_NEXT, S_FIN, S_RSP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = sbm_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd = sbm_pkg::CMD_LOAD;
            state_in = S_RD_INIT;
         end
         S_RD_INIT: begin
            // reads search byte zero; writes first count misses
            cmd = sbm_pkg::CMD_SRCH_INIT;
            state_in = stat.is_read ? S_RD_SRD : S_CM_SRD;
         end
         S_RD_SRD: if (stat.srch_done) begin
            state_in = stat.found ? S_RD_CRD : S_FIN;
         end else begin
            cmd = sbm_pkg::CMD_SRCH_RD;
            state_in = S_RD_SCMP;
         end
         S_RD_SCMP: begin
            cmd = sbm_pkg::CMD_SRCH_CMP;
            state_in = S_RD_SRD;
         end
         S_RD_CRD: begin
            cmd = sbm_pkg::CMD_RDCHK_RD;
            state_in = S_RD_CEV;
         end
         S_RD_CEV: begin
            cmd = sbm_pkg::CMD_RDCHK_EVAL;
            state_in = stat.last_byte ? S_FIN : S_RD_CRD;
         end
         S_CM_INIT: begin
            cmd = sbm_pkg::CMD_SRCH_INIT;
            state_in = S_CM_SRD;
         end
         S_CM_SRD: if (stat.srch_done) begin
            state_in = S_CM_NEXT;
         end else begin
            cmd = sbm_pkg::CMD_SRCH_RD;
            state_in = S_CM_SCMP;
         end
         S_CM_SCMP: begin
            cmd = sbm_pkg::CMD_SRCH_CMP;
            state_in = S_CM_SRD;
         end
         S_CM_NEXT: begin
            cmd = sbm_pkg::CMD_COUNT_MISS;
            state_in = stat.last_byte ? S_W_CHK : S_CM_INIT;
         end
         S_W_CHK: if (stat.no_room) begin
            // refused unchanged, miss count kept for the full status
            state_in = S_FIN;
         end else begin
            cmd = sbm_pkg::CMD_WR_START;
            state_in = S_W_INIT;
         end
         S_W_INIT: begin
            cmd = sbm_pkg::CMD_SRCH_INIT;
            state_in = S_W_SRD;
         end
         S_W_SRD: if (stat.srch_done) begin
            state_in = stat.found ? S_W_URD : S_W_SHRD;
         end else begin
            cmd = sbm_pkg::CMD_SRCH_RD;
            state_in = S_W_SCMP;
         end
         S_W_SCMP: begin
            cmd = sbm_pkg::CMD_SRCH_CMP;
            state_in = S_W_SRD;
         end
         S_W_SHRD: if (stat.shift_done) begin
            state_in = S_W_INS;
         end else begin
            cmd = sbm_pkg::CMD_SHIFT_RD;
            state_in = S_W_SHWR;
         end
         S_W_SHWR: begin
            cmd = sbm_pkg::CMD_SHIFT_WR;
            state_in = S_W_SHRD;
         end
         S_W_INS: begin
            cmd = sbm_pkg::CMD_INS_WR;
            state_in = S_W_URD;
         end
         S_W_URD: begin
            cmd = sbm_pkg::CMD_UPD_RD;
            state_in = S_W_UWR;
         end
         S_W_UWR: begin
            cmd = sbm_pkg::CMD_UPD_WR;
            state_in = stat.last_byte ? S_FIN : S_W_NEXT;
         end
         S_W_NEXT: begin
            cmd = sbm_pkg::CMD_NEXT_BYTE;
            state_in = S_W_INIT;
         end
         S_FIN: begin
            cmd = sbm_pkg::CMD_FINISH;
            rsp_valid_in = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: if (rsp_ready) begin
            rsp_valid_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/sparse_byte_memory_sorted_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: a read is one binary search of byte zero (a read and a compare per probe,
// about log2(count)+1 probes) plus a read and an evaluate per segment byte; a write
// searches every byte twice, shifts count-pos entries per insert, then updates the byte.
// throughput: one request at a time; the next is taken after the response handshake.
// reset: synchronous; the entry count clears, table contents stay unwritten.
// ----------------------------------------------------------------------------
// sparse_byte_memory_sorted_table_unit
// Sparse byte memory kept in an address-sorted table.
// ----------------------------------------------------------------------------
module sparse_byte_memory_sorted_table_unit #(
   parameter int unsigned ENTRIES           = 1024,
   parameter int unsigned MAX_SEGMENT_BYTES = 8,
   parameter int unsigned CLASS_BITS        = 4
) (
   input wire logic clock,
   input wire logic reset,
   sbm_if.sink      req,
   sbm_if.source    rsp
);
   sbm_pkg::cmd_type  cmd;
   sbm_pkg::stat_type stat;

   sbm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .cmd(cmd));

   sbm_datapath #(
      .ENTRIES(ENTRIES), .MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES),
      .CLASS_BITS(CLASS_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req(req.payload), .stat(stat), .rsp(rsp.payload));
endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the sorted sparse byte memory against a behavioral copy of the
// table: random and directed reads, writes and class updates, with random
// stalls on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned TABLE_ENTRIES = 1024;
   localparam int unsigned CLASS_MASK    = 4'hF;
   localparam int unsigned IDLE_LIMIT    = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbm_if #(.payload_type(sbm_pkg::req_type)) req_ch ();
   sbm_if #(.payload_type(sbm_pkg::rsp_type)) rsp_ch ();

   sparse_byte_memory_sorted_table_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #2 clock = ~clock;

   // behavioral copy of the table
   logic [63:0] mem_addr [TABLE_ENTRIES];
   logic [11:0] mem_byte [TABLE_ENTRIES];
   int unsigned mem_count;

   sbm_pkg::req_type pending_reqs [$];
   sbm_pkg::rsp_type expected_rsps [$];
   logic [63:0] used_addrs [$];
   int unsigned errors = 0;
   bit hold_rsp = 1'b0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int unsigned idle_cycles = 0;

   function automatic bit find_addr(input logic [63:0] a, output int unsigned pos);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = mem_count;
      while (hi > lo) begin
         mid = lo + (hi - lo) / 2;
         if (mem_addr[mid] == a) begin
            pos = mid;
            return 1'b1;
         end
         if (mem_addr[mid] > a) hi = mid;
         else lo = mid + 1;
      end
      pos = lo;
      return 1'b0;
   endfunction

   function automatic int unsigned place_addr(input logic [63:0] a);
      int unsigned p;
      if (find_addr(a, p)) return p;
      for (int unsigned k = mem_count; k > p; k--) begin
         mem_addr[k] = mem_addr[k-1];
         mem_byte[k] = mem_byte[k-1];
      end
      mem_addr[p] = a;
      mem_byte[p] = '0;
      mem_count++;
      return p;
   endfunction

   function automatic sbm_pkg::rsp_type predict_access(input sbm_pkg::req_type r);
      sbm_pkg::rsp_type o;
      int unsigned s, base, idx, p, missing;
      bit np, und;
      o = '0;
      s = r.size;
      if (s == 0) s = 1;
      if (s > 8) s = 8;
      if (r.operation == sbm_pkg::OP_READ_VALUE || r.operation == sbm_pkg::OP_READ_CLASS) begin
         np = 1'b0;
         und = 1'b0;
         if (!find_addr(r.address, base)) begin
            np = 1'b1;
         end else begin
            for (int unsigned j = 0; j < s; j++) begin
               idx = base + j;
               if (idx < mem_count && mem_addr[idx] == r.address + 64'(j)) begin
                  if ((mem_byte[idx][11:8] & CLASS_MASK) == 0) und = 1'b1;
               end else begin
                  np = 1'b1;
               end
            end
         end
         o.not_present = np;
         o.undetermined = und;
         o.all_defined = !np && !und;
         if (r.operation == sbm_pkg::OP_READ_VALUE) begin
            if (np) o.status = sbm_pkg::ST_NOT_FOUND;
            else if (und) o.status = sbm_pkg::ST_UNDETERMINED;
            else
               for (int j = s - 1; j >= 0; j--)
                  o.read_data = (o.read_data << 8) | 64'(mem_byte[base + j][7:0]);
         end
      end else begin
         missing = 0;
         for (int unsigned j = 0; j < s; j++)
            if (!find_addr(r.address + 64'(j), p)) missing++;
         if (mem_count + missing > TABLE_ENTRIES) begin
            o.status = sbm_pkg::ST_FULL;
         end else begin
            for (int unsigned j = 0; j < s; j++) begin
               idx = place_addr(r.address + 64'(j));
               if (r.operation == sbm_pkg::OP_WRITE)
                  mem_byte[idx] = {4'd1, r.write_value[8*j +: 8]};
               else
                  mem_byte[idx] = {r.class_code & 4'(CLASS_MASK), mem_byte[idx][7:0]};
            end
            if (r.operation == sbm_pkg::OP_WRITE && s < 8)
               o.overflow = r.write_value & ~((64'd1 << (8 * s)) - 64'd1);
         end
      end
      return o;
   endfunction

   function automatic sbm_pkg::req_type make_req(input sbm_pkg::op_type op,
                                                 input logic [63:0] a,
                                                 input logic [3:0] sz, input logic [63:0] wv,
                                                 input logic [3:0] cc);
      sbm_pkg::req_type r;
      r.operation = op;
      r.address = a;
      r.size = sz;
      r.write_value = wv;
      r.class_code = cc;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // driver: valid and payload change on the falling edge
   int unsigned send_gap = 0;
   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
   end
   always @(negedge clock) begin
      bit taken;
      taken = req_taken;
      req_taken = 1'b0;
      if (!reset) begin
         if (taken) send_gap = $urandom_range(0, 5);
         if (req_ch.valid && !taken) begin
            // keep offering
         end else if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap--;
         end else if (pending_reqs.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pending_reqs[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver ready with random stalls and an optional long hold-off
   int unsigned recv_gap = 0;
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock) begin
      bit taken;
      taken = rsp_taken;
      rsp_taken = 1'b0;
      if (reset || hold_rsp) begin
         rsp_ch.ready <= 1'b0;
      end else if (taken) begin
         recv_gap = $urandom_range(0, 5);
         rsp_ch.ready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ch.ready <= (recv_gap == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      sbm_pkg::rsp_type exp_rsp;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(predict_access(req_ch.payload));
            void'(pending_reqs.pop_front());
            req_taken = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken = 1'b1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $realtime, rsp_ch.payload);
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_ch.payload.read_data !== exp_rsp.read_data ||
                   rsp_ch.payload.overflow !== exp_rsp.overflow ||
                   rsp_ch.payload.all_defined !== exp_rsp.all_defined ||
                   rsp_ch.payload.not_present !== exp_rsp.not_present ||
                   rsp_ch.payload.undetermined !== exp_rsp.undetermined ||
                   rsp_ch.payload.status !== exp_rsp.status) begin
                  $display("%0t: mismatch expected %p actual %p", $realtime, exp_rsp,
                           rsp_ch.payload);
                  errors++;
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || hold_rsp)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // random request: addresses mostly near earlier ones so reads hit
   function automatic sbm_pkg::req_type random_req();
      logic [63:0] a;
      logic [3:0] sz;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6 && used_addrs.size() > 0)
         a = used_addrs[$urandom_range(0, used_addrs.size() - 1)] +
             64'($urandom_range(0, 6)) - 64'd3;
      else if (pick < 8)
         a = 64'($urandom_range(0, 255)) + 64'h1000;
      else
         a = rand64();
      sz = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(1, 8));
      if (used_addrs.size() < 200) used_addrs.push_back(a);
      return make_req(sbm_pkg::op_type'($urandom_range(0, 3)), a, sz, rand64(),
                      4'($urandom_range(0, 15)));
   endfunction

   initial begin
      int unsigned hold_len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty reads, extremes, wrap, size corner cases
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_VALUE, 64'h0, 4'd1, 64'h0, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_CLASS, '1, 4'd8, 64'h0, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_WRITE, 64'h100, 4'd8, '1, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_VALUE, 64'h100, 4'd8, 64'h0, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_WRITE, 64'h200, 4'd1, 64'h0123456789ABCDEF,
                                      4'hF));
      pending_reqs.push_back(make_req(sbm_pkg::OP_WRITE, 64'h300, 4'd0, 64'hA5A5A5A5A5A5A5A5,
                                      4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_WRITE, 64'h310, 4'd15, '1, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_SET_CLASS, 64'h400, 4'd4, 64'h0, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_VALUE, 64'h400, 4'd4, 64'h0, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_CLASS, 64'h400, 4'd4, 64'h0, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_SET_CLASS, 64'h100, 4'd2, 64'h0, 4'hF));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_CLASS, 64'h0FF, 4'd3, 64'h0, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_VALUE, 64'h106, 4'd4, 64'h0, 4'h0));
      // address wrap past the top
      pending_reqs.push_back(make_req(sbm_pkg::OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFD, 4'd6,
                                      rand64(), 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_VALUE, 64'hFFFF_FFFF_FFFF_FFFD, 4'd6,
                                      64'h0, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_VALUE, 64'h0, 4'd3, 64'h0, 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_SET_CLASS, '1, 4'd1, 64'h0, 4'h1));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_CLASS, '1, 4'd1, 64'h0, 4'h0));
      used_addrs.push_back(64'h100);
      used_addrs.push_back(64'h400);

      // random with a long response hold-off in the middle
      for (int unsigned n = 0; n < 350; n++) pending_reqs.push_back(random_req());
      wait (pending_reqs.size() < 250);
      hold_rsp = 1'b1;
      hold_len = 0;
      while (hold_len < 3000) begin
         @(negedge clock);
         hold_len++;
      end
      hold_rsp = 1'b0;
      for (int unsigned n = 0; n < 200; n++) pending_reqs.push_back(random_req());

      // fill toward full with dense writes, then probe the full case
      for (int unsigned n = 0; n < 130; n++)
         pending_reqs.push_back(make_req(sbm_pkg::OP_WRITE, 64'h8000 + 64'(8 * n), 4'd8,
                                         rand64(), 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_WRITE, 64'h9_0000, 4'd8, rand64(), 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_SET_CLASS, 64'h9_1000, 4'd8, 64'h0, 4'h2));
      pending_reqs.push_back(make_req(sbm_pkg::OP_WRITE, 64'h8000, 4'd8, rand64(), 4'h0));
      pending_reqs.push_back(make_req(sbm_pkg::OP_READ_VALUE, 64'h8000, 4'd8, 64'h0, 4'h0));

      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule

// File: sim.f
hw/rtl/sbm_pkg.sv
hw/rtl/sbm_if.sv
hw/rtl/sbm_ram.sv
hw/rtl/sbm_datapath.sv
hw/rtl/sbm_ctrl.sv
hw/rtl/sparse_byte_memory_sorted_table_unit.sv
verif/tb.sv
